[rtl/http_rlp_pkg.sv]
// ----------------------------------------------------------------------------
// http_rlp_pkg
// Shared types and constants for the request-line parser: the parser
// states, the status codes, the offset width and the character codes.
// ----------------------------------------------------------------------------
package http_rlp_pkg;

  // line buffer size and offset counter range
  localparam int LINE_BYTES = 4096;
  localparam int OFF_W      = 12;
  localparam int OFF_LIMIT  = (LINE_BYTES - 1) < ((1 << OFF_W) - 1) ?
                              (LINE_BYTES - 1) : ((1 << OFF_W) - 1);
  localparam logic [OFF_W-1:0] OFFSET_MAX = OFF_LIMIT[OFF_W-1:0];

  localparam int VER_W  = 8;
  localparam int PREF_W = 24;

  // request-line parser states, one-hot
  typedef enum logic [14:0] {
    ST_START       = 15'b000000000000001,
    ST_METHOD      = 15'b000000000000010,
    ST_SP_URI      = 15'b000000000000100,
    ST_URI         = 15'b000000000001000,
    ST_HTTP        = 15'b000000000010000,
    ST_H           = 15'b000000000100000,
    ST_HT          = 15'b000000001000000,
    ST_HTT         = 15'b000000010000000,
    ST_HTTP_SLASH  = 15'b000000100000000,
    ST_MAJ0        = 15'b000001000000000,
    ST_MAJ         = 15'b000010000000000,
    ST_MIN0        = 15'b000100000000000,
    ST_MIN         = 15'b001000000000000,
    ST_SP_END      = 15'b010000000000000,
    ST_CR          = 15'b100000000000000
  } parse_state_t;

  // per-byte status
  typedef enum logic [1:0] {
    RES_AGAIN      = 2'd0,
    RES_DONE       = 2'd1,
    RES_BAD_METHOD = 2'd2,
    RES_BAD_REQ    = 2'd3
  } status_t;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [PREF_W-1:0] GET_WORD = {CH_G, CH_E, CH_T};
  localparam logic [OFF_W-1:0]  GET_LEN  = OFF_W'(3);
  localparam logic [VER_W-1:0]  VER_SAT  = {VER_W{1'b1}};

  // upper-case letter or underscore
  function automatic logic is_method_char(input logic [7:0] c);
    return ((c >= CH_A) && (c <= CH_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // v * 10 + digit, saturating at the top of the version range
  function automatic logic [VER_W-1:0] sat_dec(input logic [VER_W-1:0] v,
                                               input logic [7:0] c);
    logic [11:0] acc;
    logic [11:0] dig;
    dig = {4'd0, c - CH_0};
    acc = ({4'd0, v} << 3) + ({4'd0, v} << 1) + dig;
    return (acc > {4'd0, VER_SAT}) ? VER_SAT : acc[VER_W-1:0];
  endfunction

endpackage

[rtl/http_request_line_parser_core.sv]
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// Byte-serial HTTP request-line parser with status, method, versions and
// field offsets reported after every byte.
// ----------------------------------------------------------------------------
// One byte enters per cycle and one result leaves per byte: the byte is
// held in an input register, the parser step runs between that register
// and the result register, and the result register doubles as the output
// stage, so a full rate of one byte per cycle holds as long as the result
// side does not stall. The parser skips
// leading CR/LF, checks the method (upper case or underscore, GET flagged),
// then the URI, "HTTP/", major.minor versions (saturating at 255), optional
// spaces and CR LF or a bare LF. After line done or any error all parser
// state returns to its reset values and the next byte starts a new line.
// Offsets count from the first byte after the previous line end or error
// and saturate at the top of the offset range.
module http_request_line_parser_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic                             out_method_code,
  output logic [http_rlp_pkg::VER_W-1:0]   out_version_major,
  output logic [http_rlp_pkg::VER_W-1:0]   out_version_minor,
  output logic [http_rlp_pkg::OFF_W-1:0]   out_line_start_pos,
  output logic [http_rlp_pkg::OFF_W-1:0]   out_method_end_pos,
  output logic [http_rlp_pkg::OFF_W-1:0]   out_uri_start_pos,
  output logic [http_rlp_pkg::OFF_W-1:0]   out_uri_end_pos,
  output logic [http_rlp_pkg::OFF_W-1:0]   out_line_end_pos
);
  import http_rlp_pkg::*;

  // input stage
  logic             in_vld_r;
  logic [7:0]       in_byte_r;

  // parser state
  parse_state_t     state_r, state_nxt;
  logic [OFF_W-1:0] byte_off_r, byte_off_nxt;
  logic [OFF_W-1:0] start_off_r, start_off_nxt;
  logic [OFF_W-1:0] meth_end_r, meth_end_nxt;
  logic [OFF_W-1:0] uri_start_r, uri_start_nxt;
  logic [OFF_W-1:0] uri_end_r, uri_end_nxt;
  logic [OFF_W-1:0] end_off_r, end_off_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic [VER_W-1:0] major_r, major_nxt;
  logic [VER_W-1:0] minor_r, minor_nxt;
  logic             is_get_r, is_get_nxt;
  logic [PREF_W-1:0] prefix_r, prefix_nxt;

  // output stage
  logic             out_vld_r;
  status_t          res_r;
  logic             res_get_r;
  logic [VER_W-1:0] res_major_r, res_minor_r;
  logic [OFF_W-1:0] res_start_r, res_meth_end_r, res_uri_start_r;
  logic [OFF_W-1:0] res_uri_end_r, res_end_r;

  // step results before the end-of-line clear
  status_t          res;
  parse_state_t     st_upd;
  logic [OFF_W-1:0] start_upd, meth_end_upd, uri_start_upd, uri_end_upd, end_upd;
  logic             end_seen_upd, is_get_upd;
  logic [VER_W-1:0] major_upd, minor_upd;
  logic [PREF_W-1:0] prefix_upd;

  logic             out_free;
  logic             step;
  logic [7:0]       c;
  logic [OFF_W-1:0] pos;

  // handshake and pipeline advance
  assign out_free = !out_vld_r || !out_stall;
  assign step     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign c        = in_byte_r;
  assign pos      = byte_off_r;

  // one parser step
  always_comb begin
    res           = RES_AGAIN;
    st_upd        = state_r;
    start_upd     = start_off_r;
    meth_end_upd  = meth_end_r;
    uri_start_upd = uri_start_r;
    uri_end_upd   = uri_end_r;
    end_upd       = end_off_r;
    end_seen_upd  = end_seen_r;
    major_upd     = major_r;
    minor_upd     = minor_r;
    is_get_upd    = is_get_r;
    prefix_upd    = prefix_r;
    unique case (state_r)
      ST_START: begin
        start_upd = pos;
        if ((c == CH_CR) || (c == CH_LF)) begin
          st_upd = ST_START;
        end else if (!is_method_char(c)) begin
          res = RES_BAD_METHOD;
        end else begin
          prefix_upd = {16'd0, c};
          st_upd     = ST_METHOD;
        end
      end
      ST_METHOD: begin
        if (c == CH_SP) begin
          meth_end_upd = pos;
          is_get_upd   = ((pos - start_off_r) == GET_LEN) && (prefix_r == GET_WORD);
          st_upd       = ST_SP_URI;
        end else if (!is_method_char(c)) begin
          res = RES_BAD_METHOD;
        end else begin
          prefix_upd = {prefix_r[PREF_W-9:0], c};
        end
      end
      ST_SP_URI: begin
        if (c == CH_SLASH) begin
          uri_start_upd = pos;
          st_upd        = ST_URI;
        end else if (c != CH_SP) begin
          res = RES_BAD_REQ;
        end
      end
      ST_URI: begin
        if (c == CH_SP) begin
          uri_end_upd = pos;
          st_upd      = ST_HTTP;
        end
      end
      ST_HTTP: begin
        if (c == CH_H) st_upd = ST_H;
        else if (c != CH_SP) res = RES_BAD_REQ;
      end
      ST_H: begin
        if (c == CH_T) st_upd = ST_HT; else res = RES_BAD_REQ;
      end
      ST_HT: begin
        if (c == CH_T) st_upd = ST_HTT; else res = RES_BAD_REQ;
      end
      ST_HTT: begin
        if (c == CH_P) st_upd = ST_HTTP_SLASH; else res = RES_BAD_REQ;
      end
      ST_HTTP_SLASH: begin
        if (c == CH_SLASH) st_upd = ST_MAJ0; else res = RES_BAD_REQ;
      end
      ST_MAJ0: begin
        if ((c < CH_1) || (c > CH_9)) begin
          res = RES_BAD_REQ;
        end else begin
          major_upd = VER_W'(c - CH_0);
          st_upd    = ST_MAJ;
        end
      end
      ST_MAJ: begin
        if (c == CH_DOT) st_upd = ST_MIN0;
        else if (!is_digit(c)) res = RES_BAD_REQ;
        else major_upd = sat_dec(major_r, c);
      end
      ST_MIN0: begin
        if (!is_digit(c)) begin
          res = RES_BAD_REQ;
        end else begin
          minor_upd = VER_W'(c - CH_0);
          st_upd    = ST_MIN;
        end
      end
      ST_MIN: begin
        if (c == CH_CR) begin
          end_upd      = pos;
          end_seen_upd = 1'b1;
          st_upd       = ST_CR;
        end else if (c == CH_LF) begin
          res = RES_DONE;
        end else if (c == CH_SP) begin
          st_upd = ST_SP_END;
        end else if (is_digit(c)) begin
          minor_upd = sat_dec(minor_r, c);
        end else begin
          res = RES_BAD_REQ;
        end
      end
      ST_SP_END: begin
        if (c == CH_CR) begin
          end_upd      = pos;
          end_seen_upd = 1'b1;
          st_upd       = ST_CR;
        end else if (c == CH_LF) begin
          res = RES_DONE;
        end else if (c != CH_SP) begin
          res = RES_BAD_REQ;
        end
      end
      ST_CR: begin
        res = (c == CH_LF) ? RES_DONE : RES_BAD_REQ;
      end
      default: begin
        st_upd = ST_START;
        res    = RES_BAD_REQ;
      end
    endcase
    // bare LF ends the line at the LF itself
    if ((res == RES_DONE) && !end_seen_r) end_upd = pos;
  end

  // next state: clear after done or error, else keep the step results
  always_comb begin
    if (res != RES_AGAIN) begin
      state_nxt     = ST_START;
      byte_off_nxt  = '0;
      start_off_nxt = '0;
      meth_end_nxt  = '0;
      uri_start_nxt = '0;
      uri_end_nxt   = '0;
      end_off_nxt   = '0;
      end_seen_nxt  = 1'b0;
      major_nxt     = '0;
      minor_nxt     = '0;
      is_get_nxt    = 1'b0;
      prefix_nxt    = '0;
    end else begin
      state_nxt     = st_upd;
      byte_off_nxt  = (pos < OFFSET_MAX) ? pos + OFF_W'(1) : pos;
      start_off_nxt = start_upd;
      meth_end_nxt  = meth_end_upd;
      uri_start_nxt = uri_start_upd;
      uri_end_nxt   = uri_end_upd;
      end_off_nxt   = end_upd;
      end_seen_nxt  = end_seen_upd;
      major_nxt     = major_upd;
      minor_nxt     = minor_upd;
      is_get_nxt    = is_get_upd;
      prefix_nxt    = prefix_upd;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (!in_stall && in_valid) in_byte_r <= in_data_byte;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      byte_off_r  <= '0;
      start_off_r <= '0;
      meth_end_r  <= '0;
      uri_start_r <= '0;
      uri_end_r   <= '0;
      end_off_r   <= '0;
      end_seen_r  <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
      is_get_r    <= 1'b0;
      prefix_r    <= '0;
    end else if (step) begin
      state_r     <= state_nxt;
      byte_off_r  <= byte_off_nxt;
      start_off_r <= start_off_nxt;
      meth_end_r  <= meth_end_nxt;
      uri_start_r <= uri_start_nxt;
      uri_end_r   <= uri_end_nxt;
      end_off_r   <= end_off_nxt;
      end_seen_r  <= end_seen_nxt;
      major_r     <= major_nxt;
      minor_r     <= minor_nxt;
      is_get_r    <= is_get_nxt;
      prefix_r    <= prefix_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (step) begin
      res_r           <= res;
      res_get_r       <= is_get_upd;
      res_major_r     <= major_upd;
      res_minor_r     <= minor_upd;
      res_start_r     <= start_upd;
      res_meth_end_r  <= meth_end_upd;
      res_uri_start_r <= uri_start_upd;
      res_uri_end_r   <= uri_end_upd;
      res_end_r       <= end_upd;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = res_r;
  assign out_method_code    = res_get_r;
  assign out_version_major  = res_major_r;
  assign out_version_minor  = res_minor_r;
  assign out_line_start_pos = res_start_r;
  assign out_method_end_pos = res_meth_end_r;
  assign out_uri_start_pos  = res_uri_start_r;
  assign out_uri_end_pos    = res_uri_end_r;
  assign out_line_end_pos   = res_end_r;

endmodule
